### src/jptc_pkg.sv
// Package for the jet patch trigger combiner: payload structs, register
// indexes, field widths and the configuration bundle. No dependencies.
package jptc_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SUM_W   = 6;
	localparam int unsigned HSUM_W  = 7;
	localparam int unsigned LEVEL_W = 2;
	localparam int unsigned HT_B_W  = 4;
	localparam int unsigned HT_E_W  = 2;
	localparam int unsigned RING_N  = 6;

	// Field positions inside the sector and endcap words
	localparam int unsigned SUM_LSB = 6;
	localparam int unsigned ID_LSB  = 12;
	localparam int unsigned HT_B_LSB = 12;
	localparam int unsigned HT_E_LSB = 14;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_THR_LOW  = 2'd0,
		CFG_THR_MID  = 2'd1,
		CFG_THR_HIGH = 2'd2,
		CFG_ADJ_THR  = 2'd3
	} cfg_index_t;

	// Endcap patch IDs
	localparam logic [1:0] PATCH_NONE = 2'd0;
	localparam logic [1:0] PATCH_ONE  = 2'd1;
	localparam logic [1:0] PATCH_TWO  = 2'd2;
	localparam logic [1:0] PATCH_THREE = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] sector_word_0;
		logic [WORD_W-1:0] sector_word_1;
		logic [WORD_W-1:0] sector_word_2;
		logic [WORD_W-1:0] sector_word_3;
		logic [WORD_W-1:0] sector_word_4;
		logic [WORD_W-1:0] sector_word_5;
		logic [WORD_W-1:0] endcap_word_a;
		logic [WORD_W-1:0] endcap_word_b;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] trigger_word;
		logic [HSUM_W-1:0] hybrid_sum_a;
		logic [HSUM_W-1:0] hybrid_sum_b;
	} result_t;

	typedef struct packed {
		logic [HSUM_W-1:0]  thr_low;
		logic [HSUM_W-1:0]  thr_mid;
		logic [HSUM_W-1:0]  thr_high;
		logic [LEVEL_W-1:0] adj_thr;
	} cfg_t;

	// Patch-level summary handed from the patch logic to the top level
	typedef struct packed {
		logic [HT_B_W-1:0]  ht_barrel;
		logic [HT_E_W-1:0]  ht_endcap;
		logic [LEVEL_W-1:0] max_barrel;
		logic [LEVEL_W-1:0] max_endcap;
		logic               adj_barrel;
		logic               adj_endcap;
	} patch_info_t;

endpackage

### src/jet_patch_trigger_combiner_top.sv
// Top level of the jet patch trigger combiner: input register, hybrid sum and
// patch logic, result register. Uses jptc_pkg, jptc_hybrid and jptc_patch.
//
// One word set is taken every clock while item_stall is low. The accepting
// edge loads the input register; the result register loads from it when it is
// empty or its result is being taken, with all combining logic
// between them. While the result register is held by result_stall, one more
// word set is still taken into the input register; item_stall rises only when
// both registers are full and the result is held.
// Thresholds are written through cfg_we/cfg_index/cfg_data and are expected
// to change only while no word set is in flight.
module jet_patch_trigger_combiner_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  jptc_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output jptc_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [jptc_pkg::HSUM_W-1:0]    cfg_data
);

	jptc_pkg::cfg_t        cfg_q;
	jptc_pkg::item_t       item_s1;
	logic                  valid_s1;
	jptc_pkg::result_t     result_s2;
	logic                  valid_s2;
	logic                  load_s1, load_s2;
	logic [jptc_pkg::HSUM_W-1:0]  sum_a, sum_b;
	logic [jptc_pkg::LEVEL_W-1:0] count, level;
	jptc_pkg::patch_info_t info;
	logic [jptc_pkg::WORD_W-1:0]  word;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (jptc_pkg::cfg_index_t'(cfg_index))
				jptc_pkg::CFG_THR_LOW:  cfg_q.thr_low  <= cfg_data;
				jptc_pkg::CFG_THR_MID:  cfg_q.thr_mid  <= cfg_data;
				jptc_pkg::CFG_THR_HIGH: cfg_q.thr_high <= cfg_data;
				jptc_pkg::CFG_ADJ_THR:  cfg_q.adj_thr  <= cfg_data[jptc_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the pipeline when the next stage is free
	assign load_s2    = valid_s1 && (!valid_s2 || !result_stall);
	assign load_s1    = item_valid && !item_stall;
	assign item_stall = valid_s1 && valid_s2 && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold input item
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= item;
		end
	end

	jptc_hybrid u_hybrid (
		.item  (item_s1),
		.cfg   (cfg_q),
		.sum_a (sum_a),
		.sum_b (sum_b),
		.count (count)
	);

	jptc_patch u_patch (
		.item    (item_s1),
		.adj_thr (cfg_q.adj_thr),
		.info    (info)
	);

	// Raise the level to the largest patch level and pack the word
	always_comb begin
		level = count;
		if (info.max_barrel > level) level = info.max_barrel;
		if (info.max_endcap > level) level = info.max_endcap;
		word = {level != 2'd0,
		        info.adj_endcap,
		        info.adj_barrel,
		        info.adj_barrel | info.adj_endcap,
		        info.max_endcap > 2'd2,
		        info.max_endcap > 2'd1,
		        info.max_barrel > 2'd2,
		        info.max_barrel > 2'd1,
		        level > 2'd2,
		        level > 2'd1,
		        info.ht_endcap,
		        info.ht_barrel};
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2.trigger_word <= word;
			result_s2.hybrid_sum_a <= sum_a;
			result_s2.hybrid_sum_b <= sum_b;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Input stalls only when both stages hold items and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("item_stall raised with a free stage");

	// Adjacency summary bit matches its parts
	a_adj_or: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.trigger_word[12] ==
		                  (result.trigger_word[13] | result.trigger_word[14])))
		else $error("adjacency summary mismatch");

	// Level flags are nested
	a_level_nest: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.trigger_word[6] |-> result.trigger_word[15])
		else $error("level flags out of order");

	// The level is never below the barrel or endcap maximum
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.trigger_word[9] || result.trigger_word[11])
		|-> result.trigger_word[7])
		else $error("level below patch maximum");

	// A stage loaded from a full input register drains it unless refilled
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && !load_s1 |=> !valid_s1)
		else $error("input register not drained");

endmodule

### src/jptc_hybrid.sv
// Hybrid jet sums: endcap partial sum plus the barrel sector picked by the
// patch ID, and the threshold count over both sums. Uses jptc_pkg.
module jptc_hybrid (
	input  jptc_pkg::item_t                 item,
	input  jptc_pkg::cfg_t                  cfg,
	output logic [jptc_pkg::HSUM_W-1:0]     sum_a,
	output logic [jptc_pkg::HSUM_W-1:0]     sum_b,
	output logic [jptc_pkg::LEVEL_W-1:0]    count
);

	logic [jptc_pkg::SUM_W-1:0] part_a, part_b, add_a, add_b;
	logic [1:0]                 id_a, id_b;
	logic                       over_low, over_mid, over_high;

	// Pick the barrel partial sum for each endcap half
	always_comb begin
		part_a = item.endcap_word_a[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
		part_b = item.endcap_word_b[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
		id_a   = item.endcap_word_a[jptc_pkg::ID_LSB +: 2];
		id_b   = item.endcap_word_b[jptc_pkg::ID_LSB +: 2];
		case (id_a)
			jptc_pkg::PATCH_ONE:   add_a = item.sector_word_3[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
			jptc_pkg::PATCH_TWO:   add_a = item.sector_word_4[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
			jptc_pkg::PATCH_THREE: add_a = item.sector_word_5[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
			default:               add_a = '0;
		endcase
		case (id_b)
			jptc_pkg::PATCH_ONE:   add_b = item.sector_word_0[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
			jptc_pkg::PATCH_TWO:   add_b = item.sector_word_1[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
			jptc_pkg::PATCH_THREE: add_b = item.sector_word_2[jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
			default:               add_b = '0;
		endcase
	end

	assign sum_a = {1'b0, part_a} + {1'b0, add_a};
	assign sum_b = {1'b0, part_b} + {1'b0, add_b};

	// Count thresholds passed by either sum
	assign over_low  = (sum_a > cfg.thr_low)  || (sum_b > cfg.thr_low);
	assign over_mid  = (sum_a > cfg.thr_mid)  || (sum_b > cfg.thr_mid);
	assign over_high = (sum_a > cfg.thr_high) || (sum_b > cfg.thr_high);
	assign count = {1'b0, over_low} + {1'b0, over_mid} + {1'b0, over_high};

endmodule

### src/jptc_patch.sv
// Patch-level logic: high-tower ORs, barrel and endcap maxima, and adjacent
// patch coincidences around each six-patch ring. Uses jptc_pkg.
module jptc_patch (
	input  jptc_pkg::item_t               item,
	input  logic [jptc_pkg::LEVEL_W-1:0]  adj_thr,
	output jptc_pkg::patch_info_t         info
);

	logic [jptc_pkg::WORD_W-1:0]  sector [jptc_pkg::RING_N];
	logic [jptc_pkg::LEVEL_W-1:0] ring_x [jptc_pkg::RING_N];
	logic [jptc_pkg::LEVEL_W-1:0] ring_y [jptc_pkg::RING_N];
	logic [jptc_pkg::LEVEL_W-1:0] ring_z [jptc_pkg::RING_N];
	logic [jptc_pkg::LEVEL_W-1:0] ring_e [jptc_pkg::RING_N];
	logic [jptc_pkg::LEVEL_W-1:0] max_b, max_e;
	logic [jptc_pkg::HT_B_W-1:0]  ht_b;
	logic                         hit_b, hit_e;

	assign sector[0] = item.sector_word_0;
	assign sector[1] = item.sector_word_1;
	assign sector[2] = item.sector_word_2;
	assign sector[3] = item.sector_word_3;
	assign sector[4] = item.sector_word_4;
	assign sector[5] = item.sector_word_5;

	// Split patch levels into rings
	always_comb begin
		for (int i = 0; i < jptc_pkg::RING_N; i++) begin
			ring_x[i] = sector[i][1:0];
			ring_y[i] = sector[i][3:2];
			ring_z[i] = sector[i][5:4];
		end
		ring_e[0] = item.endcap_word_a[1:0];
		ring_e[1] = item.endcap_word_a[3:2];
		ring_e[2] = item.endcap_word_a[5:4];
		ring_e[3] = item.endcap_word_b[1:0];
		ring_e[4] = item.endcap_word_b[3:2];
		ring_e[5] = item.endcap_word_b[5:4];
	end

	// OR high towers and take the largest level on each side
	always_comb begin
		ht_b  = '0;
		max_b = '0;
		max_e = '0;
		for (int i = 0; i < jptc_pkg::RING_N; i++) begin
			ht_b = ht_b | sector[i][jptc_pkg::HT_B_LSB +: jptc_pkg::HT_B_W];
			if (ring_x[i] > max_b) max_b = ring_x[i];
			if (ring_y[i] > max_b) max_b = ring_y[i];
			if (ring_z[i] > max_b) max_b = ring_z[i];
			if (ring_e[i] > max_e) max_e = ring_e[i];
		end
	end

	// Flag neighboring patches that both pass the threshold, wrapping the ring
	always_comb begin
		hit_b = 1'b0;
		hit_e = 1'b0;
		for (int i = 0; i < jptc_pkg::RING_N; i++) begin
			if (ring_x[i] > adj_thr && ring_x[(i + 1) % jptc_pkg::RING_N] > adj_thr) hit_b = 1'b1;
			if (ring_y[i] > adj_thr && ring_y[(i + 1) % jptc_pkg::RING_N] > adj_thr) hit_b = 1'b1;
			if (ring_z[i] > adj_thr && ring_z[(i + 1) % jptc_pkg::RING_N] > adj_thr) hit_b = 1'b1;
			if (ring_e[i] > adj_thr && ring_e[(i + 1) % jptc_pkg::RING_N] > adj_thr) hit_e = 1'b1;
		end
	end

	assign info.ht_barrel  = ht_b;
	assign info.ht_endcap  = item.endcap_word_a[jptc_pkg::HT_E_LSB +: jptc_pkg::HT_E_W]
	                       | item.endcap_word_b[jptc_pkg::HT_E_LSB +: jptc_pkg::HT_E_W];
	assign info.max_barrel = max_b;
	assign info.max_endcap = max_e;
	assign info.adj_barrel = hit_b;
	assign info.adj_endcap = hit_e;

endmodule

### sim/testbench.sv
// Testbench for jet_patch_trigger_combiner_top: drives word sets, predicts each
// trigger word and both hybrid sums, and checks them in order as they come out.
// Depends on jptc_pkg and the block's top level only.
module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	jptc_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	jptc_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [jptc_pkg::HSUM_W-1:0] cfg_data = '0;

	// Shadow copy of the threshold registers
	logic [jptc_pkg::HSUM_W-1:0] cut_low = '0;
	logic [jptc_pkg::HSUM_W-1:0] cut_mid = '0;
	logic [jptc_pkg::HSUM_W-1:0] cut_high = '0;
	logic [jptc_pkg::LEVEL_W-1:0] adj_floor = '0;

	jptc_pkg::item_t word_sets_to_send [$];
	jptc_pkg::result_t expected_triggers [$];
	int sets_sent = 0;
	int triggers_seen = 0;
	int input_stall_cycles = 0;
	int faults = 0;
	int phases_run = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	logic calm = 1'b0;
	logic squeeze_req = 1'b0;
	logic squeeze_done;
	logic offer_next;
	jptc_pkg::result_t got;
	jptc_pkg::result_t want;

	jet_patch_trigger_combiner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// True when two neighbors around a six-patch ring both exceed the floor
	function automatic logic ring_hit(
			input logic [jptc_pkg::RING_N-1:0][jptc_pkg::LEVEL_W-1:0] lv,
			input logic [jptc_pkg::LEVEL_W-1:0] floor_lvl);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < jptc_pkg::RING_N; i++) begin
			if (lv[i] > floor_lvl && lv[(i + 1) % jptc_pkg::RING_N] > floor_lvl)
				hit = 1'b1;
		end
		return hit;
	endfunction

	// Combine one word set into the expected trigger word and hybrid sums
	function automatic jptc_pkg::result_t combine_words(input jptc_pkg::item_t ws);
		logic [jptc_pkg::WORD_W-1:0] w [8];
		logic [jptc_pkg::HSUM_W-1:0] sum_a, sum_b;
		logic [jptc_pkg::LEVEL_W-1:0] id_a, id_b, lv, max_b, max_e;
		logic [jptc_pkg::HT_B_W-1:0] ht_b;
		logic [jptc_pkg::HT_E_W-1:0] ht_e;
		logic [jptc_pkg::RING_N-1:0][jptc_pkg::LEVEL_W-1:0] ring;
		logic adj_b, adj_e;
		int level;
		jptc_pkg::result_t r;
		w[0] = ws.sector_word_0;
		w[1] = ws.sector_word_1;
		w[2] = ws.sector_word_2;
		w[3] = ws.sector_word_3;
		w[4] = ws.sector_word_4;
		w[5] = ws.sector_word_5;
		w[6] = ws.endcap_word_a;
		w[7] = ws.endcap_word_b;

		// Complete the hybrid sums; half A pairs with sectors 3..5, half B with 0..2
		sum_a = {1'b0, w[6][jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W]};
		sum_b = {1'b0, w[7][jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W]};
		id_a = w[6][jptc_pkg::ID_LSB +: jptc_pkg::LEVEL_W];
		id_b = w[7][jptc_pkg::ID_LSB +: jptc_pkg::LEVEL_W];
		if (id_a != jptc_pkg::PATCH_NONE)
			sum_a = sum_a + w[2 + id_a][jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];
		if (id_b != jptc_pkg::PATCH_NONE)
			sum_b = sum_b + w[id_b - 1][jptc_pkg::SUM_LSB +: jptc_pkg::SUM_W];

		// Gather high-tower bits and the largest patch levels
		ht_b = '0;
		ht_e = '0;
		max_b = '0;
		max_e = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < 6)
				ht_b |= w[i][jptc_pkg::HT_B_LSB +: jptc_pkg::HT_B_W];
			else
				ht_e |= w[i][jptc_pkg::HT_E_LSB +: jptc_pkg::HT_E_W];
			for (int k = 0; k < 3; k++) begin
				lv = w[i][2*k +: jptc_pkg::LEVEL_W];
				if (i < 6 && lv > max_b)
					max_b = lv;
				if (i >= 6 && lv > max_e)
					max_e = lv;
			end
		end

		// Step the level once per threshold passed, then raise it to the patch maxima
		level = 0;
		if (sum_a > cut_low || sum_b > cut_low)
			level++;
		if (sum_a > cut_mid || sum_b > cut_mid)
			level++;
		if (sum_a > cut_high || sum_b > cut_high)
			level++;
		if (max_b > level)
			level = max_b;
		if (max_e > level)
			level = max_e;

		// Barrel rings run per level slot; the endcap ring is A,B,C of half A then half B
		adj_b = 1'b0;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < jptc_pkg::RING_N; i++)
				ring[i] = w[i][2*k +: jptc_pkg::LEVEL_W];
			adj_b |= ring_hit(ring, adj_floor);
		end
		for (int k = 0; k < 3; k++) begin
			ring[k] = w[6][2*k +: jptc_pkg::LEVEL_W];
			ring[k + 3] = w[7][2*k +: jptc_pkg::LEVEL_W];
		end
		adj_e = ring_hit(ring, adj_floor);

		r.trigger_word = {level > 0, adj_e, adj_b, adj_b | adj_e,
			max_e > 2, max_e > 1, max_b > 2, max_b > 1, level > 2, level > 1, ht_e, ht_b};
		r.hybrid_sum_a = sum_a;
		r.hybrid_sum_b = sum_b;
		return r;
	endfunction

	function automatic logic [jptc_pkg::WORD_W-1:0] sector(input logic [3:0] ht,
			input logic [5:0] sum, input logic [1:0] z, input logic [1:0] y,
			input logic [1:0] x);
		return {ht, sum, z, y, x};
	endfunction

	function automatic logic [jptc_pkg::WORD_W-1:0] endcap(input logic [1:0] ht,
			input logic [1:0] id, input logic [5:0] sum, input logic [1:0] c,
			input logic [1:0] b, input logic [1:0] a);
		return {ht, id, sum, c, b, a};
	endfunction

	// Random word set; a third of them keep only a few patch levels lit
	function automatic jptc_pkg::item_t random_set();
		logic [7:0][jptc_pkg::WORD_W-1:0] w;
		w = {$urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 2) == 0) begin
			for (int i = 0; i < 8; i++)
				for (int k = 0; k < 3; k++)
					if ($urandom_range(0, 3) != 0)
						w[i][2*k +: jptc_pkg::LEVEL_W] = '0;
		end
		return jptc_pkg::item_t'(w);
	endfunction

	task automatic load_thresholds(input logic [jptc_pkg::HSUM_W-1:0] lo,
			input logic [jptc_pkg::HSUM_W-1:0] mid,
			input logic [jptc_pkg::HSUM_W-1:0] hi,
			input logic [jptc_pkg::HSUM_W-1:0] adj);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= jptc_pkg::CFG_THR_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= jptc_pkg::CFG_THR_MID;
		cfg_data <= mid;
		@(posedge clk);
		cfg_index <= jptc_pkg::CFG_THR_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= jptc_pkg::CFG_ADJ_THR;
		cfg_data <= adj;
		@(posedge clk);
		cfg_we <= 1'b0;
		cut_low = lo;
		cut_mid = mid;
		cut_high = hi;
		adj_floor = adj[jptc_pkg::LEVEL_W-1:0];
	endtask

	// Hold until every queued set went in and every result came back;
	// look at the falling edge so the driver's updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (word_sets_to_send.size() != 0 || item_valid || expected_triggers.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_directed();
		jptc_pkg::item_t d;
		// all zero and all one
		d = '0;
		word_sets_to_send.push_back(d);
		d = '1;
		word_sets_to_send.push_back(d);
		// patch ID zero on both halves, full partial sums on both halves and sectors 0 and 3
		d = '0;
		d.sector_word_0 = sector(0, 63, 0, 0, 0);
		d.sector_word_3 = sector(0, 63, 0, 0, 0);
		d.endcap_word_a = endcap(0, jptc_pkg::PATCH_NONE, 63, 0, 0, 0);
		d.endcap_word_b = endcap(0, jptc_pkg::PATCH_NONE, 63, 0, 0, 0);
		word_sets_to_send.push_back(d);
		// each patch ID on each half, sector sums distinct so the pick is visible
		for (int k = 1; k <= 3; k++) begin
			d = '0;
			d.sector_word_0 = sector(0, 1, 0, 0, 0);
			d.sector_word_1 = sector(0, 2, 0, 0, 0);
			d.sector_word_2 = sector(0, 4, 0, 0, 0);
			d.sector_word_3 = sector(0, 8, 0, 0, 0);
			d.sector_word_4 = sector(0, 16, 0, 0, 0);
			d.sector_word_5 = sector(0, 32, 0, 0, 0);
			d.endcap_word_a = endcap(0, 2'(k), 0, 0, 0, 0);
			d.endcap_word_b = endcap(0, 2'(4 - k), 0, 0, 0, 0);
			word_sets_to_send.push_back(d);
		end
		// largest hybrid sums
		d = '0;
		d.sector_word_2 = sector(0, 63, 0, 0, 0);
		d.sector_word_5 = sector(0, 63, 0, 0, 0);
		d.endcap_word_a = endcap(0, jptc_pkg::PATCH_THREE, 63, 0, 0, 0);
		d.endcap_word_b = endcap(0, jptc_pkg::PATCH_THREE, 63, 0, 0, 0);
		word_sets_to_send.push_back(d);
		// barrel adjacency on X across the wrap from sector 5 to 0
		d = '0;
		d.sector_word_5 = sector(0, 0, 0, 0, 3);
		d.sector_word_0 = sector(0, 0, 0, 0, 3);
		word_sets_to_send.push_back(d);
		// barrel adjacency on Y between sectors 2 and 3
		d = '0;
		d.sector_word_2 = sector(0, 0, 0, 2, 0);
		d.sector_word_3 = sector(0, 0, 0, 2, 0);
		word_sets_to_send.push_back(d);
		// barrel adjacency on Z between sectors 4 and 5
		d = '0;
		d.sector_word_4 = sector(0, 0, 1, 0, 0);
		d.sector_word_5 = sector(0, 0, 1, 0, 0);
		word_sets_to_send.push_back(d);
		// no adjacency: alternating sectors, and neighbors lit on different slots
		d = '0;
		d.sector_word_0 = sector(0, 0, 0, 0, 3);
		d.sector_word_2 = sector(0, 0, 0, 0, 3);
		d.sector_word_4 = sector(0, 0, 0, 0, 3);
		d.sector_word_1 = sector(0, 0, 0, 3, 0);
		word_sets_to_send.push_back(d);
		// endcap adjacency from C of half A to A of half B
		d = '0;
		d.endcap_word_a = endcap(0, 0, 0, 3, 0, 0);
		d.endcap_word_b = endcap(0, 0, 0, 0, 0, 3);
		word_sets_to_send.push_back(d);
		// endcap adjacency across the wrap from C of half B to A of half A
		d = '0;
		d.endcap_word_a = endcap(0, 0, 0, 0, 0, 2);
		d.endcap_word_b = endcap(0, 0, 0, 2, 0, 0);
		word_sets_to_send.push_back(d);
		// endcap adjacency inside half A, no adjacency between A and C of one half
		d = '0;
		d.endcap_word_a = endcap(0, 0, 0, 0, 1, 1);
		d.endcap_word_b = endcap(0, 0, 0, 1, 0, 1);
		word_sets_to_send.push_back(d);
		// high-tower bits one at a time
		d = '0;
		d.sector_word_0 = sector(4'h1, 0, 0, 0, 0);
		d.sector_word_1 = sector(4'h2, 0, 0, 0, 0);
		d.sector_word_2 = sector(4'h4, 0, 0, 0, 0);
		d.sector_word_3 = sector(4'h8, 0, 0, 0, 0);
		d.endcap_word_a = endcap(2'h1, 0, 0, 0, 0, 0);
		d.endcap_word_b = endcap(2'h2, 0, 0, 0, 0, 0);
		word_sets_to_send.push_back(d);
		d = '0;
		d.sector_word_5 = sector(4'hf, 0, 0, 0, 0);
		d.endcap_word_b = endcap(2'h3, 0, 0, 0, 0, 0);
		word_sets_to_send.push_back(d);
		// single patch levels in barrel and endcap
		for (int l = 1; l <= 3; l++) begin
			d = '0;
			d.sector_word_4 = sector(0, 0, 2'(l), 0, 0);
			word_sets_to_send.push_back(d);
			d = '0;
			d.endcap_word_b = endcap(0, 0, 0, 0, 2'(l), 0);
			word_sets_to_send.push_back(d);
		end
	endtask

	// Driver: offer queued word sets, predict on acceptance, idle in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			offer_next = item_valid;
			if (item_valid && item_stall)
				input_stall_cycles++;
			if (item_valid && !item_stall) begin
				expected_triggers.push_back(combine_words(item));
				sets_sent++;
				offer_next = 1'b0;
			end
			if (!offer_next) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (word_sets_to_send.size() != 0) begin
					if (!calm && $urandom_range(0, 7) == 0) begin
						send_gap <= $urandom_range(0, 8);
					end else begin
						offer_next = 1'b1;
						item <= word_sets_to_send.pop_front();
					end
				end
			end
			item_valid <= offer_next;
		end
	end

	// Receiver: stall in random bursts, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			squeeze_done <= 1'b0;
		end else if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (squeeze_req && !squeeze_done) begin
			result_stall <= 1'b1;
			hold_left <= 80;
			squeeze_done <= 1'b1;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			faults++;
			if (faults <= 60)
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
		end
	endtask

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			got = result;
			triggers_seen++;
			if (expected_triggers.size() == 0) begin
				faults++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
			end else begin
				want = expected_triggers.pop_front();
				check_field("trigger_word", want.trigger_word, got.trigger_word);
				check_field("hybrid_sum_a", want.hybrid_sum_a, got.hybrid_sum_a);
				check_field("hybrid_sum_b", want.hybrid_sum_b, got.hybrid_sum_b);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("%0t: run timed out", $time);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [jptc_pkg::HSUM_W-1:0] lo, mid, hi, adj;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets under reset thresholds
		queue_directed();
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin lo = 7'd127; mid = 7'd127; hi = 7'd127; adj = 7'd3; end
				1: begin lo = 7'd0; mid = 7'd0; hi = 7'd0; adj = 7'd0; end
				2: begin lo = 7'd10; mid = 7'd40; hi = 7'd90; adj = 7'h7d; end
				3: begin lo = 7'd63; mid = 7'd62; hi = 7'd64; adj = 7'd2; end
				default: begin
					lo = 7'($urandom_range(0, 127));
					mid = 7'($urandom_range(0, 127));
					hi = 7'($urandom_range(0, 127));
					adj = 7'($urandom_range(0, 127));
				end
			endcase
			load_thresholds(lo, mid, hi, adj);
			if (ph == 7)
				calm = 1'b1;
			for (int n = 0; n < 150; n++)
				word_sets_to_send.push_back(random_set());
			// back up the result side while the sender keeps offering
			if (ph == 2)
				squeeze_req = 1'b1;
			wait_idle();
			phases_run++;
		end

		repeat (6) @(posedge clk);
		if (expected_triggers.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_triggers.size());
			faults += expected_triggers.size();
		end
		$display("Sent %0d word sets over %0d threshold settings, checked %0d results.",
			sets_sent, phases_run + 1, triggers_seen);
		$display("Input side held off for %0d cycles; %0d field mismatches.",
			input_stall_cycles, faults);
		if (faults == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
